### rtl/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg
// Types and constants shared by the saturating fact alu and its units.
// ----------------------------------------------------------------------------
`default_nettype none

package sfa_pkg;

   typedef enum logic [3:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_MUL   = 4'd2,
      OP_DIV   = 4'd3,
      OP_MOD   = 4'd4,
      OP_ABS   = 4'd5,
      OP_NEG   = 4'd6,
      OP_MIN   = 4'd7,
      OP_MAX   = 4'd8,
      OP_CLAMP = 4'd9,
      OP_SHR   = 4'd10,
      OP_SHL   = 4'd11,
      OP_SCALE = 4'd12,
      OP_ASSGN = 4'd13,
      OP_ACCUM = 4'd14,
      OP_NONE  = 4'd15
   } op_type;

   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [3:0]         kind;
      logic [7:0]         target_index;
      logic               left_from_literal;
      logic [7:0]         left_index;
      logic signed [31:0] left_const;
      logic               right_from_literal;
      logic [7:0]         right_index;
      logic signed [31:0] right_const;
      logic signed [31:0] scale_value;
   } req_type;

   typedef struct packed {
      logic               written;
      logic [7:0]         result_index;
      logic signed [31:0] result_value;
      logic [31:0]        ops_done;
   } rsp_type;

   // saturate a 66-bit signed value into 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'(S32_MAX)) r = S32_MAX;
      else if (v < 66'(S32_MIN)) r = S32_MIN;
      else r = v[31:0];
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/sfa_serial_muldiv.sv
// ----------------------------------------------------------------------------
// sfa_serial_muldiv
// Bit-serial signed multiply (32x32->64) then restoring divide (64/32),
// one bit per cycle. Quotient truncates toward zero, remainder follows the
// dividend. Divide by zero is left to the caller.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_serial_muldiv
   import sfa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               do_mul,
   input  wire logic               do_div,
   input  wire logic signed [31:0] mul_a,
   input  wire logic signed [31:0] mul_b,
   input  wire logic signed [63:0] div_num,
   input  wire logic signed [31:0] div_den,
   output logic                    done,
   output logic signed [63:0]      product,
   output logic signed [63:0]      quotient,
   output logic signed [31:0]      remainder
);

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_type;

   state_type          state_ff;
   logic [5:0]         cnt_ff;
   logic [63:0]        acc_ff;      // product accumulator / quotient shifter
   logic [31:0]        mcand_ff;    // multiplicand magnitude
   logic [31:0]        mplier_ff;   // multiplier bits, shifted out lsb first
   logic [31:0]        rem_ff;      // partial remainder
   logic [31:0]        den_ff;
   logic               pneg_ff, qneg_ff, rneg_ff, div_ff;
   logic               done_ff;

   logic [31:0] ua, ub, ud;
   logic [63:0] un;
   logic [64:0] psum;
   logic [63:0] pnext;
   logic [32:0] rtry;
   logic [32:0] rsub;

   assign ua = mul_a[31] ? 32'(-mul_a) : mul_a;
   assign ub = mul_b[31] ? 32'(-mul_b) : mul_b;
   assign ud = div_den[31] ? 32'(-div_den) : div_den;
   assign un = div_num[63] ? 64'(-div_num) : div_num;

   // one add of the shifted multiplicand into the upper half
   assign psum  = {1'b0, mplier_ff[0] ? mcand_ff : 32'd0} + {1'b0, acc_ff[63:32]};
   assign pnext = {psum[32:0], acc_ff[31:1]};
   // one restoring step
   assign rtry = {rem_ff, acc_ff[63]};
   assign rsub = rtry - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cnt_ff    <= '0;
                  mcand_ff  <= ua;
                  mplier_ff <= ub;
                  acc_ff    <= do_mul ? 64'd0 : un;
                  rem_ff    <= '0;
                  den_ff    <= ud;
                  pneg_ff   <= mul_a[31] ^ mul_b[31];
                  qneg_ff   <= div_num[63] ^ div_den[31];
                  rneg_ff   <= div_num[63];
                  div_ff    <= do_div;
                  state_ff  <= do_mul ? S_MUL : (do_div ? S_DIV : S_FIN);
               end
            end
            S_MUL: begin
               acc_ff    <= pnext;
               mplier_ff <= mplier_ff >> 1;
               if (cnt_ff == 6'd31) begin
                  cnt_ff   <= '0;
                  // signed product out, its magnitude stays as the dividend
                  product  <= pneg_ff ? -$signed(pnext) : $signed(pnext);
                  qneg_ff  <= pneg_ff ^ div_den[31];
                  rneg_ff  <= pneg_ff;
                  state_ff <= div_ff ? S_DIV : S_FIN;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            S_DIV: begin
               if (!rsub[32]) begin
                  rem_ff <= rsub[31:0];
                  acc_ff <= {acc_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= rtry[31:0];
                  acc_ff <= {acc_ff[62:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) state_ff <= S_FIN;
            end
            S_FIN: begin
               quotient  <= qneg_ff ? -$signed(acc_ff) : $signed(acc_ff);
               remainder <= rneg_ff ? 32'(-rem_ff) : rem_ff;
               done_ff   <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = done_ff;

   // a finished operation returns to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == S_IDLE) else $error("muldiv done out of idle");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && cnt_ff == 6'd63 |=> state_ff == S_FIN)
      else $error("divide did not finish");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |=> !done_ff || state_ff == S_IDLE)
      else $error("muldiv state slip");

endmodule

`default_nettype wire

### rtl/saturating_fact_alu.sv
// ----------------------------------------------------------------------------
// saturating_fact_alu
// ALU over a store of signed 32-bit facts, with a bit-serial mul/div unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation item (valid/ready). rsp_* returns exactly one
//   result item per request (valid/ready). csr_write_enable/csr_write_data
//   set fact_count; write it only while no item is in flight.
//   One item is worked at a time. After acceptance the states S_RDA, S_RDB
//   and S_RDT take the left operand, right operand and target fact from the
//   single-port store, and S_EXEC starts the mul/div unit. Every op, also
//   one with no multiply or divide, then passes S_WAIT and S_DONE. Multiply
//   and accumulate with a zero divisor add a bit-serial multiply, divide and
//   modulo a bit-serial divide, scale and accumulate with a divisor both: the
//   bit-serial mul/div unit sets the rate for those. A new item is taken the
//   cycle after a result is posted, so none is accepted while one is worked.
//   Reset clears the counter and fact_count, then a pass over every entry
//   zeroes the store; req_ready stays low during that pass.
//   A stalled receiver holds the result in the output register; one more
//   item is worked meanwhile and waits at the end until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module saturating_fact_alu
   import sfa_pkg::*;
#(
   parameter int FACT_DEPTH = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_write_enable,
   input  wire logic [8:0] csr_write_data
);

   localparam int AW = (FACT_DEPTH > 1) ? $clog2(FACT_DEPTH) : 1;
   localparam int CW = $clog2(FACT_DEPTH + 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_RDA, S_RDB, S_RDT, S_EXEC, S_WAIT, S_DONE
   } state_type;

   state_type   state_ff;
   req_type     req_ff;
   logic [8:0]  count_ff;
   logic [31:0] ops_ff;
   logic [AW-1:0] clr_ff;
   logic [31:0] mem [FACT_DEPTH];
   logic [31:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic signed [31:0] a_ff, b_ff, t_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [CW-1:0] limit;
   logic          tgt_ok, wr, rsp_post;
   logic signed [31:0] r;
   logic signed [65:0] wide;
   logic [31:0] ua;
   logic [4:0]  sh;
   logic        md_start, md_mul, md_div, md_done;
   logic signed [63:0] md_prod, md_quot;
   logic signed [31:0] md_rem;
   op_type      op;

   // effective count is the smaller of the register and the depth
   assign limit = ({23'd0, count_ff} < 32'(FACT_DEPTH)) ? CW'(count_ff) : CW'(FACT_DEPTH);
   assign tgt_ok = CW'(req_ff.target_index) < limit && 32'(req_ff.target_index) < FACT_DEPTH;
   assign op = op_type'(req_ff.kind);

   // result leaves the last stage once the output register is free
   assign rsp_post = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   function automatic logic idx_ok(input logic [7:0] i, input logic [CW-1:0] lim);
      return (32'(i) < FACT_DEPTH) && (CW'(i) < lim);
   endfunction

   // read address per phase
   always_comb begin
      unique case (state_ff)
         S_IDLE:  rd_addr = AW'(req_data.left_index);
         S_RDA:   rd_addr = AW'(req_ff.right_index);
         default: rd_addr = AW'(req_ff.target_index);
      endcase
   end

   // fact memory with registered read, zeroed by the pass after reset
   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (state_ff == S_CLEAR) mem[clr_ff] <= '0;
      else if (rsp_post && wr) mem[AW'(req_ff.target_index)] <= r;
   end

   // multiply/divide selection
   assign md_mul = (op == OP_MUL) || (op == OP_SCALE) || (op == OP_ACCUM);
   assign md_div = (op == OP_DIV) || (op == OP_MOD) || (op == OP_SCALE) ||
                   (op == OP_ACCUM && req_ff.scale_value != 0);
   assign md_start = state_ff == S_EXEC;

   sfa_serial_muldiv u_md (
      .clock(clock), .reset(reset), .start(md_start),
      .do_mul(md_mul), .do_div(md_div),
      .mul_a(a_ff), .mul_b(b_ff),
      .div_num(md_mul ? 64'sd0 : 64'(a_ff)), .div_den(md_mul ? req_ff.scale_value : b_ff),
      .done(md_done), .product(md_prod), .quotient(md_quot), .remainder(md_rem)
   );

   // result selection
   always_comb begin
      ua = a_ff;
      sh = b_ff[4:0];
      wide = '0;
      wr = tgt_ok;
      unique case (op)
         OP_ADD:   r = sat32(66'(a_ff) + 66'(b_ff));
         OP_SUB:   r = sat32(66'(a_ff) - 66'(b_ff));
         OP_MUL:   r = md_prod[31:0];
         OP_DIV:   r = (b_ff == 0) ? 32'sd0 : md_quot[31:0];
         OP_MOD:   r = (b_ff == 0) ? 32'sd0 : md_rem;
         OP_ABS:   r = a_ff[31] ? 32'(-a_ff) : a_ff;
         OP_NEG:   r = 32'(-a_ff);
         OP_MIN:   r = (a_ff < b_ff) ? a_ff : b_ff;
         OP_MAX:   r = (a_ff > b_ff) ? a_ff : b_ff;
         OP_CLAMP: r = (a_ff < b_ff) ? b_ff :
                       ((a_ff > req_ff.scale_value) ? req_ff.scale_value : a_ff);
         OP_SHR:   r = a_ff >>> sh;
         OP_SHL:   r = ua << sh;
         OP_SCALE: r = (req_ff.scale_value == 0) ? 32'sd0 : sat32(66'(md_quot));
         OP_ASSGN: r = a_ff;
         OP_ACCUM: begin
            wide = 66'(t_ff) + ((req_ff.scale_value == 0) ? 66'(md_prod) : 66'(md_quot));
            r = sat32(wide);
         end
         default: begin
            r = '0;
            wr = 1'b0;
         end
      endcase
      if (!wr) r = '0;
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         ops_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) count_ff <= csr_write_data;
         if (rsp_post) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(FACT_DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req_valid && req_ready) begin
               req_ff   <= req_data;
               state_ff <= S_RDA;
            end
            S_RDA: begin
               a_ff <= req_ff.left_from_literal ? req_ff.left_const :
                       idx_ok(req_ff.left_index, limit) ? rd_ff : 32'sd0;
               state_ff <= S_RDB;
            end
            S_RDB: begin
               b_ff <= req_ff.right_from_literal ? req_ff.right_const :
                       idx_ok(req_ff.right_index, limit) ? rd_ff : 32'sd0;
               state_ff <= S_RDT;
            end
            S_RDT: begin
               t_ff <= tgt_ok ? rd_ff : 32'sd0;
               state_ff <= S_EXEC;
            end
            S_EXEC: state_ff <= S_WAIT;
            S_WAIT: if (md_done) state_ff <= S_DONE;
            S_DONE: if (rsp_post) begin
               ops_ff <= ops_ff + 32'd1;
               rsp_ff.written      <= wr;
               rsp_ff.result_index <= req_ff.target_index;
               rsp_ff.result_value <= r;
               rsp_ff.ops_done     <= ops_ff + 32'd1;
               state_ff            <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a waiting result stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result dropped or changed");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_post |=> ops_ff == $past(ops_ff) + 32'd1)
      else $error("counter slip");
   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.written |-> rsp_ff.result_value == 0)
      else $error("value without write");

endmodule

`default_nettype wire

### verif/saturating_fact_alu_tb.sv
// ----------------------------------------------------------------------------
// saturating_fact_alu_tb
// Drives operation items into the fact alu under random idling on both
// channels, predicts every result from a local copy of the fact store and
// op counter, and compares each result item field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module saturating_fact_alu_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfa_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int REQ_BITS       = $bits(req_type);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_enable = 1'b0;
   logic [8:0] csr_write_data = '0;

   // predictor state
   logic signed [31:0] fact_mem [256];
   logic [31:0]        ops_seen;
   logic [8:0]         count_in_use;
   rsp_type            pending_results [$];

   int  error_count = 0;
   int  idle_cycles = 0;
   bit  calm_mode   = 1'b0;
   bit  hold_rsp    = 1'b0;
   int  rsp_gap     = 0;

   saturating_fact_alu i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return S32_MAX;
      if (v < -66'sd2147483648) return S32_MIN;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] fetch_operand(input logic lit,
         input logic [7:0] idx, input logic signed [31:0] value);
      if (lit) return value;
      if (idx < count_in_use) return fact_mem[idx];
      return 0;
   endfunction

   // compute the expected result of one item and update the fact store
   function automatic rsp_type alu_predict(input req_type it);
      logic signed [31:0] a, b, sc, r;
      logic signed [65:0] prod, w;
      logic [4:0] sh;
      logic wr;
      rsp_type res;
      a  = fetch_operand(it.left_from_literal, it.left_index, it.left_const);
      b  = fetch_operand(it.right_from_literal, it.right_index, it.right_const);
      sc = it.scale_value;
      sh = b[4:0];
      prod = 66'(a) * 66'(b);
      r  = 0;
      wr = 1'b1;
      ops_seen = ops_seen + 1;
      if (it.target_index >= count_in_use) begin
         wr = 1'b0;
      end else begin
         case (op_type'(it.kind))
            OP_ADD:   r = clip32(66'(a) + 66'(b));
            OP_SUB:   r = clip32(66'(a) - 66'(b));
            OP_MUL:   r = prod[31:0];
            OP_DIV: begin
               if (b == 0) r = 0;
               else if (a == S32_MIN && b == -1) r = S32_MIN;
               else r = a / b;
            end
            OP_MOD: begin
               if (b == 0 || (a == S32_MIN && b == -1)) r = 0;
               else r = a % b;
            end
            OP_ABS:   r = (a < 0) ? -a : a;
            OP_NEG:   r = -a;
            OP_MIN:   r = (a < b) ? a : b;
            OP_MAX:   r = (a > b) ? a : b;
            OP_CLAMP: r = (a < b) ? b : ((a > sc) ? sc : a);
            OP_SHR:   r = a >>> sh;
            OP_SHL:   r = a << sh;
            OP_SCALE: r = (sc == 0) ? 0 : clip32(prod / 66'(sc));
            OP_ASSGN: r = a;
            OP_ACCUM: begin
               w = prod;
               if (sc != 0) w = w / 66'(sc);
               r = clip32(66'(fact_mem[it.target_index]) + w);
            end
            default:  wr = 1'b0;
         endcase
      end
      if (wr) fact_mem[it.target_index] = r;
      res.written      = wr;
      res.result_index = it.target_index;
      res.result_value = wr ? r : 0;
      res.ops_done     = ops_seen;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // occasional random idle burst on the request side, skipped in calm mode
   task automatic idle_burst();
      if (!calm_mode && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic send_item(input req_type it);
      idle_burst();
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(alu_predict(it));
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", rsp_data.ops_done, 32'd0);
         end else begin
            rsp_type want;
            want = pending_results.pop_front();
            if (rsp_data.written !== want.written)
               report_mismatch("written", 32'(rsp_data.written), 32'(want.written));
            if (rsp_data.result_index !== want.result_index)
               report_mismatch("result_index", 32'(rsp_data.result_index),
                               32'(want.result_index));
            if (rsp_data.result_value !== want.result_value)
               report_mismatch("result_value", rsp_data.result_value,
                               want.result_value);
            if (rsp_data.ops_done !== want.ops_done)
               report_mismatch("ops_done", rsp_data.ops_done, want.ops_done);
         end
      end
   end

   // receiver with random stalls and an optional long hold-off
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!calm_mode && $urandom_range(0, 5) == 0) begin
         rsp_gap   <= $urandom_range(1, 15) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_fact_count(input logic [8:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      count_in_use = value > 256 ? 9'd256 : value;
   endtask

   function automatic logic signed [31:0] edge_value();
      case ($urandom_range(0, 7))
         0: return S32_MAX;
         1: return S32_MIN;
         2: return 0;
         3: return -1;
         4: return 1;
         5: return $urandom_range(0, 64) - 32;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_item(input int span);
      req_type it;
      it.kind               = 4'($urandom_range(0, 15));
      it.target_index       = 8'($urandom_range(0, span));
      it.left_from_literal  = 1'($urandom_range(0, 1));
      it.left_index         = 8'($urandom_range(0, span));
      it.left_const         = edge_value();
      it.right_from_literal = 1'($urandom_range(0, 1));
      it.right_index        = 8'($urandom_range(0, span));
      it.right_const        = edge_value();
      it.scale_value        = edge_value();
      if ($urandom_range(0, 9) == 0)
         it = req_type'(REQ_BITS'({$urandom, $urandom, $urandom, $urandom}));
      return it;
   endfunction

   function automatic req_type lit_item(input op_type op, input logic [7:0] tgt,
         input logic signed [31:0] a, input logic signed [31:0] b,
         input logic signed [31:0] sc);
      req_type it;
      it = '0;
      it.kind = op;
      it.target_index = tgt;
      it.left_from_literal = 1'b1;
      it.left_const = a;
      it.right_from_literal = 1'b1;
      it.right_const = b;
      it.scale_value = sc;
      return it;
   endfunction

   // writes with fact_count still zero must not land
   task automatic test_after_reset();
      send_item(lit_item(OP_ASSGN, 8'd0, 32'sd5, 0, 0));
      send_item(lit_item(OP_ADD, 8'd255, S32_MAX, 1, 0));
   endtask

   // extremes and every operation with its corner cases
   task automatic test_directed();
      req_type it;
      set_fact_count(9'd256);
      send_item(lit_item(OP_ADD, 8'd0, S32_MAX, 32'sd1, 0));
      send_item(lit_item(OP_SUB, 8'd1, S32_MIN, 32'sd1, 0));
      send_item(lit_item(OP_MUL, 8'd2, S32_MAX, S32_MAX, 0));
      send_item(lit_item(OP_DIV, 8'd3, S32_MIN, -32'sd1, 0));
      send_item(lit_item(OP_DIV, 8'd4, 32'sd7, 32'sd0, 0));
      send_item(lit_item(OP_MOD, 8'd5, -32'sd7, 32'sd3, 0));
      send_item(lit_item(OP_MOD, 8'd6, S32_MIN, -32'sd1, 0));
      send_item(lit_item(OP_ABS, 8'd7, S32_MIN, 0, 0));
      send_item(lit_item(OP_NEG, 8'd8, S32_MIN, 0, 0));
      send_item(lit_item(OP_MIN, 8'd9, -32'sd3, 32'sd4, 0));
      send_item(lit_item(OP_MAX, 8'd10, -32'sd3, 32'sd4, 0));
      send_item(lit_item(OP_CLAMP, 8'd11, 32'sd50, 32'sd0, 32'sd20));
      send_item(lit_item(OP_SHR, 8'd12, S32_MIN, 32'sd63, 0));
      send_item(lit_item(OP_SHL, 8'd13, -32'sd1, 32'sd31, 0));
      send_item(lit_item(OP_SCALE, 8'd14, S32_MAX, S32_MAX, 32'sd1));
      send_item(lit_item(OP_SCALE, 8'd15, 32'sd9, 32'sd9, 32'sd0));
      send_item(lit_item(OP_ACCUM, 8'd0, S32_MAX, S32_MAX, 32'sd0));
      send_item(lit_item(OP_ACCUM, 8'd1, S32_MIN, 32'sd2, -32'sd1));
      send_item(lit_item(OP_NONE, 8'd2, 32'sd1, 32'sd1, 0));
      // operands read from stored facts
      it = lit_item(OP_ADD, 8'd255, 0, 0, 0);
      it.left_from_literal = 1'b0;
      it.left_index = 8'd0;
      it.right_from_literal = 1'b0;
      it.right_index = 8'd1;
      send_item(it);
      set_fact_count(9'd3);
      it.target_index = 8'd2;
      it.right_index = 8'd200;
      send_item(it);
      send_item(lit_item(OP_ASSGN, 8'd3, 32'sd1, 0, 0));
   endtask

   // random items across several fact counts
   task automatic test_random();
      logic [8:0] counts [5] = '{9'd1, 9'd256, 9'd16, 9'd0, 9'd8};
      foreach (counts[k]) begin
         set_fact_count(counts[k]);
         repeat (220) send_item(random_item(counts[k] == 256 ? 255 : 31));
      end
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      set_fact_count(9'd12);
      hold_rsp = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         repeat (20) send_item(random_item(15));
      join
   endtask

   // final stretch with no idling
   task automatic test_full_rate();
      wait_idle();
      calm_mode = 1'b1;
      repeat (150) send_item(random_item(15));
   endtask

   initial begin
      foreach (fact_mem[k]) fact_mem[k] = 0;
      ops_seen = 0;
      count_in_use = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_directed();
      test_random();
      test_backpressure();
      test_full_rate();
      wait_idle();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
